FILE: src/i2ch_pkg.sv
// ----------------------------------------------------------------------------
// I2C host controller package
// Shared constants, codes, types and the bus page decoder.
// ----------------------------------------------------------------------------
package i2ch_pkg;

    localparam int NUM_BUSES       = 3;
    // Must be a power of two: the device index is the low address bits.
    localparam int DEVICES_PER_BUS = 256;

    localparam int BUS_W     = 2;
    localparam int DEV_IDX_W = $clog2(DEVICES_PER_BUS);
    localparam int MEM_AW    = BUS_W + DEV_IDX_W;
    localparam int MEM_DEPTH = NUM_BUSES * DEVICES_PER_BUS;

    // Access kinds
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_HWRITE = 2'd2;
    localparam logic [1:0] CMD_BAD    = 2'd3;

    // Register offsets
    localparam logic [7:0] OFF_DATA    = 8'd0;
    localparam logic [7:0] OFF_CTRL    = 8'd1;
    localparam logic [7:0] OFF_CNT_LO  = 8'd2;
    localparam logic [7:0] OFF_CNT_HI  = 8'd4;

    // Bus pages
    localparam logic [7:0] PAGE_BUS0 = 8'h61;
    localparam logic [7:0] PAGE_BUS1 = 8'h44;
    localparam logic [7:0] PAGE_BUS2 = 8'h48;

    // Control register bits
    localparam int CTRL_STOP_BIT  = 0;
    localparam int CTRL_START_BIT = 1;
    localparam int CTRL_ACK_BIT   = 4;
    localparam int CTRL_DIR_BIT   = 5;
    localparam int CTRL_RUN_BIT   = 7;

    typedef struct packed {
        logic             ok;
        logic [BUS_W-1:0] idx;
    } bus_sel_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] ptr;
    } ptr_entry_t;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        ptr_entry_t        data;
    } ptr_wr_t;

    function automatic bus_sel_t page_to_bus(input logic [7:0] page);
        bus_sel_t s;
        s.ok  = 1'b1;
        s.idx = '0;
        unique case (page)
            PAGE_BUS0: s.idx = BUS_W'(0);
            PAGE_BUS1: s.idx = BUS_W'(1);
            PAGE_BUS2: s.idx = BUS_W'(2);
            default:   s.ok  = 1'b0;
        endcase
        if (int'(s.idx) >= NUM_BUSES) begin
            s.ok  = 1'b0;
            s.idx = '0;
        end
        return s;
    endfunction

endpackage

FILE: src/i2ch_ptr_store.sv
// ----------------------------------------------------------------------------
// I2C host pointer store
// Per-device valid bit and register pointer, one single-port-write memory
// with registered read, write-to-read bypass and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module i2ch_ptr_store
    import i2ch_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MEM_AW-1:0] rd_addr,
    input  ptr_wr_t           wr,
    output ptr_entry_t        rd_data,
    output logic              clearing
);

    ptr_entry_t        mem [MEM_DEPTH];
    ptr_entry_t        q_reg;
    ptr_entry_t        fwd_data_reg;
    logic              fwd_hit_reg;
    logic              clearing_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;

    logic              we;
    logic [MEM_AW-1:0] wa;
    ptr_entry_t        wd;

    always_comb
    begin
        if (clearing_reg)
        begin
            we = 1'b1;
            wa = clr_cnt_reg;
            wd = '0;
        end
        else
        begin
            we = wr.en;
            wa = wr.addr;
            wd = wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        q_reg        <= mem[rd_addr];
        fwd_data_reg <= wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= we && (wa == rd_addr);
            if (clearing_reg)
            begin
                if (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
                clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            end
        end
    end

    // same-edge write wins over the stale read
    assign rd_data  = fwd_hit_reg ? fwd_data_reg : q_reg;
    assign clearing = clearing_reg;

endmodule

FILE: src/i2c_host_controller_top.sv
// ----------------------------------------------------------------------------
// I2C host controller top level
// Register model of a three-bus I2C host: one processor transaction per item.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge with start high and busy low; one
// transaction can be taken every cycle. It is latched into the item
// registers, then its result is registered and appears on the result ports
// for exactly one cycle, marked by done; the receiver cannot stall, so
// capture it then. After reset, busy stays high while the 768-entry
// per-device pointer memory is swept clear; that single memory write port
// sets the length of the sweep. Afterwards busy stays low. The first step
// latches the transaction and reads the device pointer memory; the second
// updates the bus registers and forms the result.
// ----------------------------------------------------------------------------
module i2c_host_controller_top
    import i2ch_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  bus_page,
    input  logic [7:0]  reg_offset,
    input  logic [15:0] write_value,
    input  logic [7:0]  device_read_byte,
    output logic        done,
    output logic [7:0]  read_value,
    output logic        access_error,
    output logic        device_access_valid,
    output logic        device_access_read,
    output logic [1:0]  device_bus,
    output logic [7:0]  device_address,
    output logic [7:0]  device_register,
    output logic [7:0]  device_write_byte
);

    // Bus register file
    logic [7:0] bus_data_reg    [NUM_BUSES];
    logic [7:0] bus_data_next   [NUM_BUSES];
    logic [7:0] bus_control_reg [NUM_BUSES];
    logic [7:0] bus_control_next[NUM_BUSES];
    logic       bus_active_reg  [NUM_BUSES];
    logic       bus_active_next [NUM_BUSES];
    logic [7:0] bus_cur_reg     [NUM_BUSES];
    logic [7:0] bus_cur_next    [NUM_BUSES];

    // Latched transaction
    logic        item_valid_reg;
    logic [1:0]  item_cmd_reg;
    bus_sel_t    item_bus_reg;
    logic [7:0]  item_off_reg;
    logic [15:0] item_val_reg;
    logic [7:0]  item_rd_reg;

    // Result registers
    logic       done_reg;
    logic [7:0] read_value_reg,  read_value_next;
    logic       error_reg,       error_next;
    logic       dev_valid_reg,   dev_valid_next;
    logic       dev_read_reg,    dev_read_next;
    logic [1:0] dev_bus_reg,     dev_bus_next;
    logic [7:0] dev_addr_reg,    dev_addr_next;
    logic [7:0] dev_regp_reg,    dev_regp_next;
    logic [7:0] dev_wbyte_reg,   dev_wbyte_next;

    bus_sel_t          in_bus;
    logic              accept;
    logic [MEM_AW-1:0] ptr_rd_addr;
    ptr_entry_t        ptr_rd;
    ptr_wr_t           ptr_wr;
    logic              clearing;

    assign accept = start && !busy;
    assign in_bus = page_to_bus(bus_page);

    // Prefetch the pointer entry of the bus's current device, taking into
    // account a start transfer that the transaction ahead is committing now.
    assign ptr_rd_addr = {in_bus.idx, bus_cur_next[in_bus.idx][DEV_IDX_W-1:0]};

    i2ch_ptr_store u_ptr_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (ptr_rd_addr),
        .wr       (ptr_wr),
        .rd_data  (ptr_rd),
        .clearing (clearing)
    );

    assign busy = clearing;

    // Execute stage
    always_comb
    begin
        logic [BUS_W-1:0] b;
        logic [7:0]       byte_in;
        logic [7:0]       ctrl;
        logic [7:0]       dev;
        ptr_entry_t       upd;

        for (int i = 0; i < NUM_BUSES; i++)
        begin
            bus_data_next[i]    = bus_data_reg[i];
            bus_control_next[i] = bus_control_reg[i];
            bus_active_next[i]  = bus_active_reg[i];
            bus_cur_next[i]     = bus_cur_reg[i];
        end

        read_value_next = '0;
        error_next      = 1'b0;
        dev_valid_next  = 1'b0;
        dev_read_next   = 1'b0;
        dev_bus_next    = '0;
        dev_addr_next   = '0;
        dev_regp_next   = '0;
        dev_wbyte_next  = '0;
        ptr_wr          = '0;

        b       = item_bus_reg.idx;
        byte_in = item_val_reg[7:0];
        ctrl    = {1'b0, byte_in[6:0]};
        dev     = '0;
        upd     = '0;

        if (item_valid_reg)
        begin
            if (!item_bus_reg.ok)
            begin
                error_next = 1'b1;
            end
            else
            begin
                unique case (item_cmd_reg)
                    CMD_READ:
                    begin
                        if (item_off_reg == OFF_DATA)
                            read_value_next = bus_data_reg[b];
                        else if (item_off_reg == OFF_CTRL)
                            read_value_next = bus_control_reg[b];
                        else
                            error_next = 1'b1;
                    end
                    CMD_WRITE:
                    begin
                        if (item_off_reg == OFF_DATA)
                        begin
                            bus_data_next[b] = byte_in;
                        end
                        else if (item_off_reg == OFF_CTRL)
                        begin
                            if (byte_in[CTRL_RUN_BIT])
                            begin
                                ctrl[CTRL_ACK_BIT] = 1'b1;
                                if (ctrl[CTRL_START_BIT])
                                begin
                                    // select device; fresh selection drops its pointer
                                    dev = {bus_data_reg[b][7:1], 1'b0};
                                    if (!bus_active_reg[b])
                                    begin
                                        ptr_wr.en   = 1'b1;
                                        ptr_wr.addr = {b, dev[DEV_IDX_W-1:0]};
                                        ptr_wr.data = '0;
                                    end
                                    bus_active_next[b] = 1'b1;
                                    bus_cur_next[b]    = dev;
                                end
                                else
                                begin
                                    dev = bus_cur_reg[b];
                                    if (!ptr_rd.valid)
                                    begin
                                        // first byte loads the register pointer
                                        upd.valid = 1'b1;
                                        upd.ptr   = bus_data_reg[b];
                                    end
                                    else
                                    begin
                                        dev_valid_next = 1'b1;
                                        dev_bus_next   = b;
                                        dev_addr_next  = dev;
                                        dev_regp_next  = ptr_rd.ptr;
                                        if (ctrl[CTRL_DIR_BIT])
                                        begin
                                            bus_data_next[b] = item_rd_reg;
                                            dev_read_next    = 1'b1;
                                        end
                                        else
                                        begin
                                            dev_wbyte_next = bus_data_reg[b];
                                        end
                                        upd.valid = 1'b1;
                                        upd.ptr   = ptr_rd.ptr + 8'd1;
                                    end
                                    if (ctrl[CTRL_STOP_BIT])
                                    begin
                                        upd.valid          = 1'b0;
                                        bus_active_next[b] = 1'b0;
                                    end
                                    ptr_wr.en   = 1'b1;
                                    ptr_wr.addr = {b, dev[DEV_IDX_W-1:0]};
                                    ptr_wr.data = upd;
                                end
                            end
                            bus_control_next[b] = ctrl;
                        end
                        else
                        begin
                            error_next = 1'b1;
                        end
                    end
                    CMD_HWRITE:
                    begin
                        // count registers are accepted and ignored
                        if (item_off_reg != OFF_CNT_LO && item_off_reg != OFF_CNT_HI)
                            error_next = 1'b1;
                    end
                    CMD_BAD:
                    begin
                        error_next = 1'b1;
                    end
                endcase
            end
        end
    end

    // Control and bus state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            for (int i = 0; i < NUM_BUSES; i++)
            begin
                bus_data_reg[i]    <= '0;
                bus_control_reg[i] <= '0;
                bus_active_reg[i]  <= 1'b0;
                bus_cur_reg[i]     <= '0;
            end
        end
        else
        begin
            item_valid_reg <= accept;
            done_reg       <= item_valid_reg;
            for (int i = 0; i < NUM_BUSES; i++)
            begin
                bus_data_reg[i]    <= bus_data_next[i];
                bus_control_reg[i] <= bus_control_next[i];
                bus_active_reg[i]  <= bus_active_next[i];
                bus_cur_reg[i]     <= bus_cur_next[i];
            end
        end
    end

    // Transaction and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_cmd_reg <= cmd;
            item_bus_reg <= in_bus;
            item_off_reg <= reg_offset;
            item_val_reg <= write_value;
            item_rd_reg  <= device_read_byte;
        end
        read_value_reg <= read_value_next;
        error_reg      <= error_next;
        dev_valid_reg  <= dev_valid_next;
        dev_read_reg   <= dev_read_next;
        dev_bus_reg    <= dev_bus_next;
        dev_addr_reg   <= dev_addr_next;
        dev_regp_reg   <= dev_regp_next;
        dev_wbyte_reg  <= dev_wbyte_next;
    end

    assign done                = done_reg;
    assign read_value          = read_value_reg;
    assign access_error        = error_reg;
    assign device_access_valid = dev_valid_reg;
    assign device_access_read  = dev_read_reg;
    assign device_bus          = dev_bus_reg;
    assign device_address      = dev_addr_reg;
    assign device_register     = dev_regp_reg;
    assign device_write_byte   = dev_wbyte_reg;

`ifndef ASSERT_OFF
    // every accepted transaction yields its result, marked by done
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("result missing two cycles after accept");

    // no result without an accepted transaction
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(item_valid_reg))
        else $error("result without transaction");

    // a rejected access never reaches a device
    a_err_no_dev: assert property (@(posedge clk) disable iff (!rst_n)
        (done && access_error) |-> !device_access_valid)
        else $error("device access on erroneous transaction");

    // device reads carry no write byte
    a_read_no_wbyte: assert property (@(posedge clk) disable iff (!rst_n)
        (done && device_access_read) |-> (device_write_byte == 8'd0 && device_access_valid))
        else $error("device read with write byte");
`endif

endmodule

FILE: sim/i2ch_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C host controller result checker
// Watches the transaction and result ports, predicts each result from its own
// copy of the bus registers and device pointers, and compares in order.
// ----------------------------------------------------------------------------
module i2ch_result_checker
    import i2ch_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  bus_page,
    input  logic [7:0]  reg_offset,
    input  logic [15:0] write_value,
    input  logic [7:0]  device_read_byte,
    input  logic        done,
    input  logic [7:0]  read_value,
    input  logic        access_error,
    input  logic        device_access_valid,
    input  logic        device_access_read,
    input  logic [1:0]  device_bus,
    input  logic [7:0]  device_address,
    input  logic [7:0]  device_register,
    input  logic [7:0]  device_write_byte,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [7:0] read_value;
        logic       access_error;
        logic       dev_valid;
        logic       dev_read;
        logic [1:0] dev_bus;
        logic [7:0] dev_addr;
        logic [7:0] dev_ptr;
        logic [7:0] dev_wbyte;
    } host_result_t;

    logic [7:0] data_reg   [NUM_BUSES];
    logic [7:0] ctrl_reg   [NUM_BUSES];
    logic       dev_active [NUM_BUSES];
    logic [7:0] cur_dev    [NUM_BUSES];
    logic       ptr_valid  [NUM_BUSES][DEVICES_PER_BUS];
    logic [7:0] ptr_mem    [NUM_BUSES][DEVICES_PER_BUS];

    host_result_t pending_results[$];
    host_result_t want;

    function automatic int bus_of_page(logic [7:0] pg);
        int b;
        case (pg)
            PAGE_BUS0: b = 0;
            PAGE_BUS1: b = 1;
            PAGE_BUS2: b = 2;
            default:   b = -1;
        endcase
        if (b >= NUM_BUSES)
        begin
            b = -1;
        end
        return b;
    endfunction

    // Applies one register access to the shadow state and returns its result.
    function automatic host_result_t apply_access(
        logic [1:0] c, logic [7:0] pg, logic [7:0] off, logic [15:0] v, logic [7:0] rdb);
        host_result_t r;
        int           b;
        int           idx;
        logic [7:0]   wb;
        logic [7:0]   cv;
        logic [7:0]   dv;
        r = '0;
        b = bus_of_page(pg);
        if (b < 0 || c == CMD_BAD)
        begin
            r.access_error = 1'b1;
            return r;
        end
        case (c)
            CMD_READ:
            begin
                if (off == OFF_DATA)
                    r.read_value = data_reg[b];
                else if (off == OFF_CTRL)
                    r.read_value = ctrl_reg[b];
                else
                    r.access_error = 1'b1;
            end
            CMD_WRITE:
            begin
                wb = v[7:0];
                if (off == OFF_DATA)
                begin
                    data_reg[b] = wb;
                end
                else if (off == OFF_CTRL)
                begin
                    cv = wb;
                    cv[CTRL_RUN_BIT] = 1'b0;        // status reads back as zero
                    if (wb[CTRL_RUN_BIT])
                    begin
                        cv[CTRL_ACK_BIT] = 1'b1;
                        ctrl_reg[b] = cv;
                        if (cv[CTRL_START_BIT])
                        begin
                            // start: select device, stop bit has no effect here
                            dv = data_reg[b] & ~8'h01;
                            idx = int'(dv) % DEVICES_PER_BUS;
                            if (!dev_active[b])
                                ptr_valid[b][idx] = 1'b0;
                            dev_active[b] = 1'b1;
                            cur_dev[b] = dv;
                        end
                        else
                        begin
                            dv = cur_dev[b];
                            idx = int'(dv) % DEVICES_PER_BUS;
                            if (!ptr_valid[b][idx])
                            begin
                                // first byte after select loads the pointer
                                ptr_valid[b][idx] = 1'b1;
                                ptr_mem[b][idx] = data_reg[b];
                            end
                            else
                            begin
                                r.dev_valid = 1'b1;
                                r.dev_bus   = 2'(b);
                                r.dev_addr  = dv;
                                r.dev_ptr   = ptr_mem[b][idx];
                                if (cv[CTRL_DIR_BIT])
                                begin
                                    data_reg[b] = rdb;
                                    r.dev_read = 1'b1;
                                end
                                else
                                begin
                                    r.dev_wbyte = data_reg[b];
                                end
                                ptr_mem[b][idx] = ptr_mem[b][idx] + 8'd1;
                            end
                            if (cv[CTRL_STOP_BIT])
                            begin
                                ptr_valid[b][idx] = 1'b0;
                                dev_active[b] = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        ctrl_reg[b] = cv;
                    end
                end
                else
                begin
                    r.access_error = 1'b1;
                end
            end
            default:
            begin
                if (off != OFF_CNT_LO && off != OFF_CNT_HI)
                    r.access_error = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BUSES; b++)
            begin
                data_reg[b]   = '0;
                ctrl_reg[b]   = '0;
                dev_active[b] = 1'b0;
                cur_dev[b]    = '0;
                for (int d = 0; d < DEVICES_PER_BUS; d++)
                    ptr_valid[b][d] = 1'b0;
            end
            pending_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, actual read_value %h",
                             $time, read_value);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("read_value", want.read_value, read_value);
                    check_field("access_error", want.access_error, access_error);
                    check_field("device_access_valid", want.dev_valid, device_access_valid);
                    check_field("device_access_read", want.dev_read, device_access_read);
                    check_field("device_bus", want.dev_bus, device_bus);
                    check_field("device_address", want.dev_addr, device_address);
                    check_field("device_register", want.dev_ptr, device_register);
                    check_field("device_write_byte", want.dev_wbyte, device_write_byte);
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                pending_results.push_back(apply_access(cmd, bus_page, reg_offset,
                                                       write_value, device_read_byte));
            outstanding = pending_results.size();
        end
    end

endmodule

FILE: sim/tb_i2c_host_controller_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C host controller testbench
// Drives directed and random register transactions in bursts with random
// gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_i2c_host_controller_top;
    import i2ch_pkg::*;

    localparam int ITEM_TARGET = 1100;
    // Clear sweep plus the ITEM_TARGET transactions and their random gaps
    // stay well under this limit; leave a wide margin.
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [7:0]  bus_page;
    logic [7:0]  reg_offset;
    logic [15:0] write_value;
    logic [7:0]  device_read_byte;
    logic        done;
    logic [7:0]  read_value;
    logic        access_error;
    logic        device_access_valid;
    logic        device_access_read;
    logic [1:0]  device_bus;
    logic [7:0]  device_address;
    logic [7:0]  device_register;
    logic [7:0]  device_write_byte;

    int mismatches;
    int outstanding;
    int cycles;
    int burst_left;
    int n_items;

    i2c_host_controller_top u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .cmd                 (cmd),
        .bus_page            (bus_page),
        .reg_offset          (reg_offset),
        .write_value         (write_value),
        .device_read_byte    (device_read_byte),
        .done                (done),
        .read_value          (read_value),
        .access_error        (access_error),
        .device_access_valid (device_access_valid),
        .device_access_read  (device_access_read),
        .device_bus          (device_bus),
        .device_address      (device_address),
        .device_register     (device_register),
        .device_write_byte   (device_write_byte)
    );

    // Checker sits beside the DUT on the same wires.
    i2ch_result_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .cmd                 (cmd),
        .bus_page            (bus_page),
        .reg_offset          (reg_offset),
        .write_value         (write_value),
        .device_read_byte    (device_read_byte),
        .done                (done),
        .read_value          (read_value),
        .access_error        (access_error),
        .device_access_valid (device_access_valid),
        .device_access_read  (device_access_read),
        .device_bus          (device_bus),
        .device_address      (device_address),
        .device_register     (device_register),
        .device_write_byte   (device_write_byte),
        .mismatches          (mismatches),
        .outstanding         (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_i2c_host_controller_top failed");
            $finish;
        end
    end

    function automatic logic [7:0] page_of(int b);
        case (b)
            0:       return PAGE_BUS0;
            1:       return PAGE_BUS1;
            default: return PAGE_BUS2;
        endcase
    endfunction

    // Control byte: key bits by name, the rest (bits 2, 3, 4, 6) from extra.
    function automatic logic [7:0] ctrl_val(logic run, logic dir, logic strt, logic stp,
                                            logic [7:0] extra);
        logic [7:0] v;
        v = extra;
        v[CTRL_RUN_BIT]   = run;
        v[CTRL_DIR_BIT]   = dir;
        v[CTRL_START_BIT] = strt;
        v[CTRL_STOP_BIT]  = stp;
        return v;
    endfunction

    // Drop start and idle; the payload wanders meanwhile.
    task automatic idle(int n);
        start            <= 1'b0;
        cmd              <= 2'($urandom);
        bus_page         <= 8'($urandom);
        reg_offset       <= 8'($urandom);
        write_value      <= 16'($urandom);
        device_read_byte <= 8'($urandom);
        repeat (n) @(posedge clk);
    endtask

    // One transaction. Bursts of back-to-back transactions are separated by
    // random gaps; about a third of the bursts follow on with no gap at all.
    task automatic put(logic [1:0] c, logic [7:0] pg, logic [7:0] off, logic [15:0] v,
                       logic [7:0] rdb);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
                idle(gap);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start            <= 1'b1;
        cmd              <= c;
        bus_page         <= pg;
        reg_offset       <= off;
        write_value      <= v;
        device_read_byte <= rdb;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        n_items++;
    endtask

    // Anything at all: bad pages, bad offsets, cmd 3, random control writes.
    task automatic noise_item();
        logic [1:0] c;
        logic [7:0] pg;
        logic [7:0] off;
        c   = 2'($urandom_range(0, 3));
        pg  = $urandom_range(0, 1) ? page_of($urandom_range(0, 2)) : 8'($urandom);
        off = $urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom);
        put(c, pg, off, 16'($urandom), 8'($urandom));
    endtask

    // Well-formed device session: select (most of the time), load pointer, a run
    // of byte transfers in random directions, usually ending with stop.
    task automatic run_sequence();
        int         b;
        int         n;
        logic [7:0] pg;
        logic [7:0] dev;
        logic       dir;
        logic       stp;
        b   = $urandom_range(0, NUM_BUSES - 1);
        pg  = page_of(b);
        // a small pool of devices so pointers carry over between sessions
        dev = $urandom_range(0, 1) ? 8'($urandom_range(16, 23)) : 8'($urandom);
        if ($urandom_range(0, 9) != 0)
        begin
            put(CMD_WRITE, pg, OFF_DATA, {8'($urandom), dev}, 8'($urandom));
            put(CMD_WRITE, pg, OFF_CTRL,
                {8'($urandom), ctrl_val(1'b1, 1'($urandom), 1'b1, 1'($urandom), 8'($urandom))},
                8'($urandom));
        end
        put(CMD_WRITE, pg, OFF_DATA, 16'($urandom), 8'($urandom));
        put(CMD_WRITE, pg, OFF_CTRL,
            {8'($urandom), ctrl_val(1'b1, 1'b0, 1'b0, 1'b0, 8'($urandom))}, 8'($urandom));
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            dir = 1'($urandom);
            stp = (i == n - 1) && ($urandom_range(0, 3) != 0);
            if (!dir)
                put(CMD_WRITE, pg, OFF_DATA, 16'($urandom), 8'($urandom));
            put(CMD_WRITE, pg, OFF_CTRL,
                {8'($urandom), ctrl_val(1'b1, dir, 1'b0, stp, 8'($urandom))}, 8'($urandom));
            if (dir && $urandom_range(0, 1))
                put(CMD_READ, pg, OFF_DATA, 16'($urandom), 8'($urandom));
            if ($urandom_range(0, 7) == 0)
                noise_item();
        end
        if ($urandom_range(0, 3) == 0)
            put(CMD_READ, pg, OFF_CTRL, 16'($urandom), 8'($urandom));
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        start            <= 1'b0;
        cmd              <= CMD_READ;
        bus_page         <= '0;
        reg_offset       <= '0;
        write_value      <= '0;
        device_read_byte <= '0;
        burst_left = 0;
        n_items    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // registers read zero after reset
        put(CMD_READ, PAGE_BUS0, OFF_DATA, 16'h0000, 8'h00);
        put(CMD_READ, PAGE_BUS1, OFF_CTRL, 16'hFFFF, 8'hFF);
        // unknown command, unknown pages, unknown offsets
        put(CMD_BAD, PAGE_BUS0, OFF_DATA, 16'hFFFF, 8'hFF);
        put(CMD_READ, 8'h00, OFF_DATA, 16'h0000, 8'h00);
        put(CMD_WRITE, 8'hFF, OFF_CTRL, 16'hFFFF, 8'hFF);
        put(CMD_READ, PAGE_BUS2, 8'hFF, 16'h0000, 8'h00);
        put(CMD_WRITE, PAGE_BUS1, OFF_CNT_LO, 16'h00FF, 8'h00);
        // halfword writes: counter offsets accepted with no effect, others flagged
        put(CMD_HWRITE, PAGE_BUS0, OFF_CNT_LO, 16'hFFFF, 8'h00);
        put(CMD_HWRITE, PAGE_BUS2, OFF_CNT_HI, 16'h0000, 8'h00);
        put(CMD_HWRITE, PAGE_BUS1, OFF_DATA, 16'hFFFF, 8'h00);
        put(CMD_HWRITE, PAGE_BUS0, 8'hFF, 16'hFFFF, 8'h00);
        // control write without run; read back
        put(CMD_WRITE, PAGE_BUS0, OFF_CTRL, 16'hFF7F, 8'h00);
        put(CMD_READ, PAGE_BUS0, OFF_CTRL, 16'h0000, 8'h00);
        // transfer with no device selected: device 0 pointer loads, then a write
        put(CMD_WRITE, PAGE_BUS0, OFF_DATA, 16'h0012, 8'h00);
        put(CMD_WRITE, PAGE_BUS0, OFF_CTRL, {8'h00, ctrl_val(1'b1, 1'b0, 1'b0, 1'b0, 8'h00)}, 8'h00);
        put(CMD_WRITE, PAGE_BUS0, OFF_DATA, 16'h00A5, 8'h00);
        put(CMD_WRITE, PAGE_BUS0, OFF_CTRL, {8'h00, ctrl_val(1'b1, 1'b0, 1'b0, 1'b0, 8'h00)}, 8'h00);
        // start with stop: stop ignored, selects 0xFE
        put(CMD_WRITE, PAGE_BUS0, OFF_DATA, 16'h00FF, 8'h00);
        put(CMD_WRITE, PAGE_BUS0, OFF_CTRL, {8'h00, ctrl_val(1'b1, 1'b0, 1'b1, 1'b1, 8'h00)}, 8'h00);
        put(CMD_WRITE, PAGE_BUS0, OFF_DATA, 16'h0000, 8'h00);
        put(CMD_WRITE, PAGE_BUS0, OFF_CTRL, {8'h00, ctrl_val(1'b1, 1'b0, 1'b0, 1'b0, 8'h00)}, 8'h00);
        // device read, read-back, repeated start on the active device, read with stop
        put(CMD_WRITE, PAGE_BUS0, OFF_CTRL, {8'h00, ctrl_val(1'b1, 1'b1, 1'b0, 1'b0, 8'h00)}, 8'hFF);
        put(CMD_READ, PAGE_BUS0, OFF_DATA, 16'h0000, 8'h00);
        put(CMD_WRITE, PAGE_BUS0, OFF_CTRL, 16'h00FF, 8'h00);
        put(CMD_WRITE, PAGE_BUS0, OFF_CTRL, {8'hFF, ctrl_val(1'b1, 1'b1, 1'b0, 1'b1, 8'h00)}, 8'h00);

        // --- random part ---
        while (n_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 5)) noise_item();
            else
                run_sequence();
        end
        idle(1);

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("tb_i2c_host_controller_top passed");
        else
            $display("tb_i2c_host_controller_top failed");
        $finish;
    end

endmodule
